// File: rtl/mchm_pkg.sv
package mchm_pkg;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_BEAT  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICK_INC  = 2'd0;
  localparam logic [1:0] CFG_HANG_TOUT = 2'd1;
  localparam logic [1:0] CFG_CRIT_MASK = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int TICK_W  = 16;
  localparam int STUCK_W = 32;
  localparam int MASK_W  = 6;
  localparam int OP_W    = 2;
  localparam int CHAN_W  = 3;
  localparam int COUNT_W = 3;

  localparam logic [TICK_W-1:0]  TICK_INC_RST  = 16'd500;
  localparam logic [STUCK_W-1:0] HANG_TOUT_RST = 32'd2000;
  localparam logic [MASK_W-1:0]  CRIT_MASK_RST = 6'd14;

  localparam int CHANNELS_DEF = 6;

endpackage

// File: rtl/multi_channel_heartbeat_monitor_core.sv
// Latency: an armed check word yields its result word in the cycle after it is accepted.
// Throughput: one input word per cycle; every channel's stuck-time adder and timeout
// compare run in parallel in that single pass, and the output register frees the
// input side whenever its word is taken or empty.
// Reset (rst_n low, synchronous): registers to their defaults, seen marks, stuck
// times, armed and emergency stop cleared; no output word pending.
module multi_channel_heartbeat_monitor_core
  import mchm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [CHAN_W-1:0]     in_channel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_W-1:0]    out_hung_count,
  output logic [MASK_W-1:0]     out_hung_channels,
  output logic                  out_estop
);

  localparam int CNT_W = $clog2(CHANNELS + 1);

  // Configuration registers
  logic [TICK_W-1:0]  tick_inc_r;
  logic [STUCK_W-1:0] hang_tout_r;
  logic [MASK_W-1:0]  crit_mask_r;

  // Channel state
  logic [CHANNELS-1:0] seen_r, seen_nxt;
  logic [STUCK_W-1:0]  stuck_r   [CHANNELS];
  logic [STUCK_W-1:0]  stuck_nxt [CHANNELS];
  logic                armed_r, armed_nxt;
  logic                estop_r, estop_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [MASK_W-1:0]  out_hung_r, out_hung_nxt;
  logic               out_estop_r, out_estop_nxt;

  // Check datapath
  logic [STUCK_W-1:0]         stuck_sat [CHANNELS];
  logic [STUCK_W:0]           stuck_sum [CHANNELS];
  logic [CHANNELS-1:0]        hung_all;
  logic [CHANNELS+MASK_W-1:0] hung_pad;
  logic [MASK_W-1:0]          hung_lo;
  logic [CNT_W-1:0]           hung_cnt;
  logic                       accept;
  op_t                        op;

  // The input side only waits while a result word is held and not taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_operation);

  // Per-channel saturating add and timeout compare, all lanes in parallel.
  // A channel seen since the last check is never hung.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      stuck_sum[i] = {1'b0, stuck_r[i]} + {{(STUCK_W + 1 - TICK_W){1'b0}}, tick_inc_r};
      stuck_sat[i] = stuck_sum[i][STUCK_W] ? {STUCK_W{1'b1}} : stuck_sum[i][STUCK_W-1:0];
      hung_all[i]  = !seen_r[i] && (stuck_sat[i] >= hang_tout_r);
    end
  end

  // Channels past the mask width still count, but get no flag bit
  assign hung_pad = {{MASK_W{1'b0}}, hung_all};
  assign hung_lo  = hung_pad[MASK_W-1:0];
  assign hung_cnt = CNT_W'($countones(hung_all));

  always_comb begin
    seen_nxt      = seen_r;
    stuck_nxt     = stuck_r;
    armed_nxt     = armed_r;
    estop_nxt     = estop_r;
    out_count_nxt = out_count_r;
    out_hung_nxt  = out_hung_r;
    out_estop_nxt = out_estop_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (accept) begin
      case (op)
        OP_BEAT: begin
          // Mark the addressed channel; out-of-range channels drop out here
          for (int i = 0; i < CHANNELS; i++) begin
            if (int'(in_channel) == i) begin
              seen_nxt[i] = 1'b1;
            end
          end
        end
        OP_CHECK: begin
          if (armed_r) begin
            for (int i = 0; i < CHANNELS; i++) begin
              stuck_nxt[i] = seen_r[i] ? '0 : stuck_sat[i];
            end
            seen_nxt      = '0;
            estop_nxt     = estop_r || |(hung_lo & crit_mask_r);
            out_valid_nxt = 1'b1;
            // Saturate the count at the field's maximum
            out_count_nxt = (int'(hung_cnt) > 7) ? COUNT_W'(7) : COUNT_W'(hung_cnt);
            out_hung_nxt  = hung_lo;
            out_estop_nxt = estop_r || |(hung_lo & crit_mask_r);
          end
        end
        OP_CLEAR: begin
          // Arm and zero the channels; the emergency stop stays latched
          seen_nxt  = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            stuck_nxt[i] = '0;
          end
          armed_nxt = 1'b1;
        end
        default: begin
          // Undefined operation: drop the word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_inc_r  <= TICK_INC_RST;
      hang_tout_r <= HANG_TOUT_RST;
      crit_mask_r <= CRIT_MASK_RST;
      seen_r      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        stuck_r[i] <= '0;
      end
      armed_r     <= 1'b0;
      estop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes; an index beyond the list is ignored
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_INC:  tick_inc_r  <= cfg_wdata[TICK_W-1:0];
          CFG_HANG_TOUT: hang_tout_r <= cfg_wdata[STUCK_W-1:0];
          CFG_CRIT_MASK: crit_mask_r <= cfg_wdata[MASK_W-1:0];
          default: begin
          end
        endcase
      end
      seen_r      <= seen_nxt;
      stuck_r     <= stuck_nxt;
      armed_r     <= armed_nxt;
      estop_r     <= estop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_r
  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
    out_hung_r  <= out_hung_nxt;
    out_estop_r <= out_estop_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hung_count    = out_count_r;
  assign out_hung_channels = out_hung_r;
  assign out_estop         = out_estop_r;

endmodule

// File: rtl/mchm_checker.sv
module mchm_checker
  import mchm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    in_operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_hung_count,
  input logic [MASK_W-1:0]  out_hung_channels,
  input logic               out_estop
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hung_count)
      && $stable(out_hung_channels) && $stable(out_estop))
    else $error("result word changed while stalled");

  // A fresh result word follows an accepted check word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |->
      $past(in_valid && in_ready && in_operation == OP_CHECK))
    else $error("result word without a check");

  // Emergency stop, once reported, stays set
  a_estop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_estop ##1 out_valid |-> out_estop)
    else $error("emergency stop dropped");

  // With every channel inside the flag field, the count matches the flags
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHANNELS > MASK_W)
      || (int'(out_hung_count) == $countones(out_hung_channels)))
    else $error("hung count disagrees with hung flags");

endmodule

bind multi_channel_heartbeat_monitor_core mchm_checker #(.CHANNELS(CHANNELS)) u_mchm_checker (.*);

// File: tb/heartbeat_report_checker.sv
`timescale 1ns / 1ps
module heartbeat_report_checker
  import mchm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COUNT_W-1:0]    out_hung_count,
  input  logic [MASK_W-1:0]     out_hung_channels,
  input  logic                  out_estop,
  output int                    fail_count,
  output int                    pending,
  output int                    reports_checked
);

  typedef struct packed {
    logic [COUNT_W-1:0] hung_count;
    logic [MASK_W-1:0]  hung_channels;
    logic               estop;
  } hang_report_t;

  localparam int                 NOTE_LIMIT = 60;
  localparam logic [STUCK_W-1:0] STUCK_MAX  = '1;

  logic [TICK_W-1:0]   tick_inc;
  logic [STUCK_W-1:0]  hang_tout;
  logic [MASK_W-1:0]   crit_mask;
  logic [CHANNELS-1:0] seen;
  logic [STUCK_W-1:0]  stuck [CHANNELS];
  logic                armed;
  logic                estop_held;
  hang_report_t        due_reports [$];
  int                  errors = 0;
  int                  compared = 0;

  task automatic wipe_channels();
    seen = '0;
    for (int i = 0; i < CHANNELS; i++) stuck[i] = '0;
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= NOTE_LIMIT)
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  // Advance the monitor by one input word; queue a report for an armed check.
  task automatic advance_monitor(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch);
    logic [STUCK_W:0] sum;
    hang_report_t     rep;
    case (op)
      OP_BEAT: begin
        if (ch < CHANNELS) seen[ch] = 1'b1;
      end
      OP_CLEAR: begin
        wipe_channels();
        armed = 1'b1;
      end
      OP_CHECK: begin
        if (armed) begin
          rep = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            if (seen[i]) begin
              stuck[i] = '0;
            end else begin
              sum      = {1'b0, stuck[i]} + {{(STUCK_W + 1 - TICK_W){1'b0}}, tick_inc};
              stuck[i] = sum[STUCK_W] ? STUCK_MAX : sum[STUCK_W-1:0];
              if (stuck[i] >= hang_tout) begin
                if (rep.hung_count != '1) rep.hung_count = rep.hung_count + COUNT_W'(1);
                if (i < MASK_W) begin
                  rep.hung_channels[i] = 1'b1;
                  if (crit_mask[i]) estop_held = 1'b1;
                end
              end
            end
            seen[i] = 1'b0;
          end
          rep.estop = estop_held;
          due_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    hang_report_t want;
    if (!rst_n) begin
      tick_inc   = TICK_INC_RST;
      hang_tout  = HANG_TOUT_RST;
      crit_mask  = CRIT_MASK_RST;
      armed      = 1'b0;
      estop_held = 1'b0;
      wipe_channels();
      due_reports.delete();
    end else begin
      // Results first: a word accepted at this edge cannot have produced one yet.
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          errors++;
          if (errors <= NOTE_LIMIT)
            $display("%0t ns: report word with none due, expected nothing actual %0d/%0h/%0b",
                     $time, out_hung_count, out_hung_channels, out_estop);
        end else begin
          want = due_reports.pop_front();
          compared++;
          if (out_hung_count !== want.hung_count)
            note_mismatch("hung_count", int'(want.hung_count), int'(out_hung_count));
          if (out_hung_channels !== want.hung_channels)
            note_mismatch("hung_channels", int'(want.hung_channels), int'(out_hung_channels));
          if (out_estop !== want.estop)
            note_mismatch("estop", int'(want.estop), int'(out_estop));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_INC:  tick_inc  = cfg_wdata[TICK_W-1:0];
          CFG_HANG_TOUT: hang_tout = cfg_wdata[STUCK_W-1:0];
          CFG_CRIT_MASK: crit_mask = cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_monitor(in_operation, in_channel);
    end
    pending         <= due_reports.size();
    fail_count      <= errors;
    reports_checked <= compared;
  end

endmodule

// File: tb/tb_multi_channel_heartbeat_monitor_core.sv
`timescale 1ns / 1ps
module tb_multi_channel_heartbeat_monitor_core;
  import mchm_pkg::*;

  localparam int                   GAP_MAX     = 14;
  localparam int                   SETTLE      = 4;     // cycles to let the core go quiet
  localparam int                   QUIET_LIMIT = 2000;  // cycles with no word moving
  localparam int                   SAT_CHECKS  = 24;    // silent checks at the largest tick
  localparam int                   PHASES      = 10;
  localparam int                   PHASE_WORDS = 150;
  localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;  // undefined operation, ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;  // unmapped register index

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic [OP_W-1:0]       in_operation = '0;
  logic [CHAN_W-1:0]     in_channel   = '0;
  logic                  out_ready    = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [COUNT_W-1:0]    out_hung_count;
  logic [MASK_W-1:0]     out_hung_channels;
  logic                  out_estop;

  int          fail_count;
  int          pending;
  int          reports_checked;
  int          words_sent     = 0;
  int          settings_used  = 0;
  int unsigned quiet          = 0;
  int unsigned rx_hold        = 0;
  bit          tx_gaps        = 1'b1;
  bit          rx_gaps        = 1'b1;

  always #5 clk = ~clk;

  multi_channel_heartbeat_monitor_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_channel        (in_channel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hung_count    (out_hung_count),
    .out_hung_channels (out_hung_channels),
    .out_estop         (out_estop)
  );

  heartbeat_report_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_channel        (in_channel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hung_count    (out_hung_count),
    .out_hung_channels (out_hung_channels),
    .out_estop         (out_estop),
    .fail_count        (fail_count),
    .pending           (pending),
    .reports_checked   (reports_checked)
  );

  // Result side: after every report word taken, drop ready for a drawn number of
  // cycles, then raise it and hold it until the next word goes.
  always @(posedge clk) begin : rx_side
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      stall     = rx_gaps ? $urandom_range(0, GAP_MAX) : 0;
      rx_hold   <= stall;
      out_ready <= (stall == 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any word moving on either channel restarts the count. A report
  // that never arrives leaves the run stuck here and ends it.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d reports still due",
               $time, QUIET_LIMIT, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one input word and return at the edge where it is taken. A gap drops
  // valid first; with no gap valid stays high and only the payload moves on.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_channel   <= ch;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Hold the sender until every report due has been taken, then let the core
  // settle: heartbeats and clears give no report to wait for.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers, plus a junk write to the unmapped index that
  // must leave them alone. Only call while the core is idle.
  task automatic set_config(input logic [TICK_W-1:0] tick, input logic [STUCK_W-1:0] tout,
                            input logic [MASK_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK_INC;
    cfg_wdata <= CFG_DATA_W'(tick);
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_index <= CFG_HANG_TOUT;
    cfg_wdata <= tout;
    @(posedge clk);
    cfg_index <= CFG_CRIT_MASK;
    cfg_wdata <= CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Rounds of heartbeats from a drawn set of healthy channels closed by a check,
  // so stuck times build up over runs of silent checks. Now and then slip in
  // noise: out-of-range beats, the undefined operation, a clear, or a pause.
  task automatic run_traffic(input int words);
    int               first;
    int               start;
    logic [MASK_W-1:0] healthy;
    first = words_sent;
    while (words_sent - first < words) begin
      case ($urandom_range(0, 3))
        0:       healthy = '1;
        1:       healthy = '0;
        default: healthy = MASK_W'($urandom);
      endcase
      start = $urandom_range(0, CHANNELS_DEF - 1);
      for (int c = 0; c < CHANNELS_DEF; c++)
        if (healthy[(c + start) % CHANNELS_DEF])
          send_word(OP_BEAT, CHAN_W'((c + start) % CHANNELS_DEF));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_word(OP_BEAT, CHAN_W'($urandom_range(CHANNELS_DEF, 7)));
          1:       send_word(OP_SPARE, CHAN_W'($urandom));
          default: send_word(OP_CLEAR, CHAN_W'($urandom));
        endcase
      end
      send_word(OP_CHECK, CHAN_W'($urandom));
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
  endtask

  initial begin
    int unsigned       t;
    int unsigned       k;
    logic [STUCK_W-1:0] tout;
    logic [MASK_W-1:0]  mask;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset register values (tick 500, timeout 2000,
    // channels 1 to 3 critical).
    send_word(OP_CHECK, 3'd0);  // unarmed: no report, nothing moves
    send_word(OP_BEAT, 3'd7);   // out of range, ignored
    send_word(OP_BEAT, 3'd6);
    send_word(OP_BEAT, 3'd2);   // marks the channel even while unarmed
    send_word(OP_SPARE, 3'd5);  // undefined operation, ignored
    send_word(OP_CLEAR, 3'd0);  // arm
    // Keep the critical channels alive so only non-critical ones hang on the
    // fourth check: estop must stay low.
    repeat (4) begin
      send_word(OP_BEAT, 3'd1);
      send_word(OP_BEAT, 3'd2);
      send_word(OP_BEAT, 3'd3);
      send_word(OP_CHECK, 3'd0);
    end
    // Zero timeout: every silent channel hangs at once, a seen one never does.
    wait_idle();
    set_config(16'd1, '0, '0);
    send_word(OP_BEAT, 3'd0);
    send_word(OP_CHECK, 3'd7);
    send_word(OP_CHECK, 3'd4);

    // Random phases. The first ones keep the critical mask empty so estop stays
    // clear; from the fifth on it can latch and must then survive every clear.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2)
        t = 1;
      else if (p == 3)
        t = 65535;
      else
        t = $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(1, 65535);
      k    = $urandom_range(1, 4);
      tout = t * k - $urandom_range(0, t - 1);
      if (p == 0) tout = 1;
      if (p == 1) tout = '0;
      if (p < 4)
        mask = '0;
      else if (p == 4)
        mask = MASK_W'(1 << $urandom_range(0, CHANNELS_DEF - 1));
      else if (p == PHASES - 1)
        mask = '1;
      else
        mask = MASK_W'($urandom);
      tx_gaps = (p != 2) && ($urandom_range(0, 3) != 0);
      rx_gaps = (p != 2) && ($urandom_range(0, 3) != 0);
      wait_idle();
      set_config(TICK_W'(t), tout, mask);
      run_traffic(PHASE_WORDS);
    end

    // Largest tick and timeout, back-to-back checks with no heartbeat: stuck
    // times climb in big steps but stay below the timeout, so nothing hangs.
    wait_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_config('1, '1, '1);
    send_word(OP_CLEAR, 3'd0);
    repeat (SAT_CHECKS) send_word(OP_CHECK, CHAN_W'($urandom));

    wait_idle();
    $display("Covered %0d input words over %0d register settings; %0d check reports compared.",
             words_sent, settings_used + 1, reports_checked);
    $display("Included unarmed checks, ignored words, zero and maximum timeouts, largest tick.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
